FILE: sv/csat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csat_pkg
// Shared types, constants and helper functions of the clip shape transform.
// ----------------------------------------------------------------------------
package csat_pkg;

    // Fixed point format and circle tessellation.
    localparam int FRAC_BITS    = 16;
    localparam int SEGMENTS     = 32;
    localparam int MAX_OUT      = 64;
    localparam int N_VERT       = (SEGMENTS > MAX_OUT) ? MAX_OUT : SEGMENTS;
    localparam int VERT_W       = $clog2(N_VERT);
    localparam int REM_W        = $clog2(2 * SEGMENTS);

    // Turn step between circle vertices: quotient and remainder of 2^32 / SEGMENTS.
    localparam logic [31:0]      TURN_STEP = 32'((64'd1 << 32) / SEGMENTS);
    localparam logic [REM_W-1:0] TURN_REM  = REM_W'((64'd1 << 32) % SEGMENTS);
    localparam logic [REM_W-1:0] SEG_CNT   = REM_W'(SEGMENTS);
    localparam logic [VERT_W-1:0] LAST_VERT = VERT_W'(N_VERT - 1);

    // CORDIC rotator.
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    // Shared multiplier operand and product widths.
    localparam int MW = 34;
    localparam int PW = 2 * MW;

    // Commands of an input transaction.
    localparam logic [1:0] CMD_RECT   = 2'd0;
    localparam logic [1:0] CMD_RRECT  = 2'd1;
    localparam logic [1:0] CMD_POINT  = 2'd2;
    localparam logic [1:0] CMD_CIRCLE = 2'd3;

    // Kinds of a result transaction.
    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_RRECT  = 2'd1;
    localparam logic [1:0] KIND_VERTEX = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAT_XX   = 3'd0;
    localparam logic [2:0] REG_MAT_XY   = 3'd1;
    localparam logic [2:0] REG_MAT_YX   = 3'd2;
    localparam logic [2:0] REG_MAT_YY   = 3'd3;
    localparam logic [2:0] REG_OFFSET_X = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y = 3'd5;
    localparam logic [2:0] REG_ALIGN_EPS = 3'd6;

    localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic [30:0]        size_value;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] out_ax;
        logic signed [31:0] out_ay;
        logic signed [31:0] out_bx;
        logic signed [31:0] out_by;
        logic [30:0]        out_rounding;
        logic               last_out;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] mat_xx;
        logic signed [31:0] mat_xy;
        logic signed [31:0] mat_yx;
        logic signed [31:0] mat_yy;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [15:0]        align_epsilon;
    } t_cfg;

    typedef struct packed {
        t_in_item item;
        logic     aligned;
    } t_job;

    // Arctangent table in turn units (2^32 = full turn).
    function automatic logic signed [31:0] atan_turn(input logic [4:0] k);
        logic signed [31:0] v;
        unique case (k)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41721;
            5'd15: v = 32'sd20860;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2607;
            5'd19: v = 32'sd1303;
            5'd20: v = 32'sd651;
            5'd21: v = 32'sd325;
            5'd22: v = 32'sd162;
            5'd23: v = 32'sd81;
            5'd24: v = 32'sd40;
            5'd25: v = 32'sd20;
            5'd26: v = 32'sd10;
            5'd27: v = 32'sd5;
            5'd28: v = 32'sd2;
            5'd29: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v > PW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -(PW'(64'sd2147483648))) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/csat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csat_front
// Configuration registers, input acceptance, shape classification and the
// two-entry job queue that feeds the back end.
// ----------------------------------------------------------------------------
module csat_front
    import csat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output t_cfg        o_cfg,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_pop
);

    t_cfg        r_cfg;
    t_job        r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [32:0] abs_xy;
    logic [32:0] abs_yx;
    logic        aligned;
    logic        do_push;
    logic        do_pop;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mat_xx        <= ONE_FIX;
            r_cfg.mat_xy        <= '0;
            r_cfg.mat_yx        <= '0;
            r_cfg.mat_yy        <= ONE_FIX;
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.align_epsilon <= 16'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MAT_XX:    r_cfg.mat_xx        <= i_cfg_data;
                REG_MAT_XY:    r_cfg.mat_xy        <= i_cfg_data;
                REG_MAT_YX:    r_cfg.mat_yx        <= i_cfg_data;
                REG_MAT_YY:    r_cfg.mat_yy        <= i_cfg_data;
                REG_OFFSET_X:  r_cfg.offset_x      <= i_cfg_data;
                REG_OFFSET_Y:  r_cfg.offset_y      <= i_cfg_data;
                REG_ALIGN_EPS: r_cfg.align_epsilon <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Classify the matrix as axis-aligned when both shear terms are small.
    assign abs_xy  = r_cfg.mat_xy[31] ? 33'(-{r_cfg.mat_xy[31], r_cfg.mat_xy})
                                      : {1'b0, r_cfg.mat_xy};
    assign abs_yx  = r_cfg.mat_yx[31] ? 33'(-{r_cfg.mat_yx[31], r_cfg.mat_yx})
                                      : {1'b0, r_cfg.mat_yx};
    assign aligned = (abs_xy <= {17'd0, r_cfg.align_epsilon})
                  && (abs_yx <= {17'd0, r_cfg.align_epsilon});

    // Job queue between the front and the back end.
    assign full        = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rd_ptr];
    assign do_push     = push && !full;
    assign do_pop      = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= '{item: i_item, aligned: aligned};
        end
    end

endmodule

FILE: sv/csat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csat_back
// Shape sequencer: corner and circle vertex generation, CORDIC rotator,
// shared multiplier for the affine transform, and the result queue.
// ----------------------------------------------------------------------------
module csat_back
    import csat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_COR  = 5'd1;
    localparam logic [4:0] S_CQ   = 5'd2;
    localparam logic [4:0] S_CMC  = 5'd3;
    localparam logic [4:0] S_CMS  = 5'd4;
    localparam logic [4:0] S_CPY  = 5'd5;
    localparam logic [4:0] S_M0   = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_M2   = 5'd8;
    localparam logic [4:0] S_M3   = 5'd9;
    localparam logic [4:0] S_M4   = 5'd10;
    localparam logic [4:0] S_M5   = 5'd11;
    localparam logic [4:0] S_EMIT = 5'd12;
    localparam logic [4:0] S_R0   = 5'd13;
    localparam logic [4:0] S_R1   = 5'd14;
    localparam logic [4:0] S_RECT = 5'd15;

    logic [4:0]             r_state;
    t_job                   r_job;
    logic [1:0]             r_corner;
    logic [VERT_W-1:0]      r_vert;
    logic [31:0]            r_turn;
    logic [REM_W-1:0]       r_rem;
    logic [4:0]             r_k;
    logic signed [CW-1:0]   r_cx;
    logic signed [CW-1:0]   r_cy;
    logic signed [31:0]     r_cz;
    logic [1:0]             r_cq;
    logic signed [CW-1:0]   r_c;
    logic signed [CW-1:0]   r_s;
    logic signed [31:0]     r_px;
    logic signed [31:0]     r_py;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;
    logic signed [31:0]     r_tx;
    logic signed [31:0]     r_ty;
    logic signed [31:0]     r_l;
    logic signed [31:0]     r_t;
    logic signed [31:0]     r_r;
    logic signed [31:0]     r_b;
    logic [30:0]            r_rnd;
    t_out_item              r_omem [2];
    logic                   r_owr;
    logic                   r_ord;
    logic [1:0]             r_ocnt;

    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   shifted;
    logic signed [CW-1:0]   ysh;
    logic signed [CW-1:0]   xsh;
    logic [32:0]            abs_xx;
    logic [32:0]            abs_yy;
    logic [32:0]            scale;
    logic signed [PW-1:0]   rnd_full;
    logic [REM_W-1:0]       rem_sum;
    logic [31:0]            nxt_turn;
    logic [REM_W-1:0]       nxt_rem;
    logic [1:0]             nxt_corner;
    logic signed [31:0]     nl;
    logic signed [31:0]     nt;
    logic signed [31:0]     nr;
    logic signed [31:0]     nb;
    logic                   out_space;
    logic                   opush;
    t_out_item              oitem;
    logic                   do_opop;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M0:    begin mul_a = MW'(r_px); mul_b = MW'(i_cfg.mat_xx); end
            S_M1:    begin mul_a = MW'(r_py); mul_b = MW'(i_cfg.mat_yx); end
            S_M2:    begin mul_a = MW'(r_px); mul_b = MW'(i_cfg.mat_xy); end
            S_M3:    begin mul_a = MW'(r_py); mul_b = MW'(i_cfg.mat_yy); end
            S_CMC:   begin mul_a = r_c; mul_b = MW'({1'b0, r_job.item.size_value}); end
            S_CMS:   begin mul_a = r_s; mul_b = MW'({1'b0, r_job.item.size_value}); end
            S_R0:    begin mul_a = MW'({1'b0, scale}); mul_b = MW'({1'b0, r_job.item.size_value}); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Helpers for the datapath steps.
    assign shifted  = r_acc >>> FRAC_BITS;
    assign ysh      = r_cy >>> r_k;
    assign xsh      = r_cx >>> r_k;
    assign abs_xx   = i_cfg.mat_xx[31] ? 33'(-{i_cfg.mat_xx[31], i_cfg.mat_xx})
                                       : {1'b0, i_cfg.mat_xx};
    assign abs_yy   = i_cfg.mat_yy[31] ? 33'(-{i_cfg.mat_yy[31], i_cfg.mat_yy})
                                       : {1'b0, i_cfg.mat_yy};
    assign scale    = (abs_xx > abs_yy) ? abs_xx : abs_yy;
    assign rnd_full = r_prod >>> FRAC_BITS;

    // Next circle angle: exact turn fraction via quotient and remainder steps.
    assign rem_sum  = r_rem + TURN_REM;
    assign nxt_turn = r_turn + TURN_STEP + 32'(rem_sum >= SEG_CNT);
    assign nxt_rem  = (rem_sum >= SEG_CNT) ? rem_sum - SEG_CNT : rem_sum;

    assign nxt_corner = r_corner + 2'd1;

    // Bounding box including the point just transformed.
    always_comb begin
        if (r_corner == 2'd0) begin
            nl = r_tx; nr = r_tx; nt = r_ty; nb = r_ty;
        end else begin
            nl = (r_tx < r_l) ? r_tx : r_l;
            nr = (r_tx > r_r) ? r_tx : r_r;
            nt = (r_ty < r_t) ? r_ty : r_t;
            nb = (r_ty > r_b) ? r_ty : r_b;
        end
    end

    // Result selection for the result queue.
    assign out_space = (r_ocnt != 2'd2);
    always_comb begin
        opush = 1'b0;
        oitem = '{kind: KIND_VERTEX, out_ax: r_tx, out_ay: r_ty, out_bx: '0,
                  out_by: '0, out_rounding: '0, last_out: 1'b0};
        if (r_state == S_EMIT) begin
            priority case (r_job.item.command)
                CMD_POINT: begin
                    opush = out_space;
                    oitem.last_out = r_job.item.last_point;
                end
                CMD_CIRCLE: begin
                    opush = out_space;
                    oitem.last_out = (r_vert == LAST_VERT);
                end
                default: begin
                    opush = out_space && !r_job.aligned;
                    oitem.last_out = (r_corner == 2'd3);
                end
            endcase
        end else if (r_state == S_RECT) begin
            opush = out_space;
            oitem = '{kind: r_job.item.command, out_ax: r_l, out_ay: r_t, out_bx: r_r,
                      out_by: r_b, out_rounding: r_rnd, last_out: 1'b1};
        end
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= (i_job.item.command == CMD_CIRCLE) ? S_COR : S_M0;
                    end
                end
                S_COR:  r_state <= (r_k == LAST_STEP) ? S_CQ : S_COR;
                S_CQ:   r_state <= S_CMC;
                S_CMC:  r_state <= S_CMS;
                S_CMS:  r_state <= S_CPY;
                S_CPY:  r_state <= S_M0;
                S_M0:   r_state <= S_M1;
                S_M1:   r_state <= S_M2;
                S_M2:   r_state <= S_M3;
                S_M3:   r_state <= S_M4;
                S_M4:   r_state <= S_M5;
                S_M5:   r_state <= S_EMIT;
                S_EMIT: begin
                    priority case (r_job.item.command)
                        CMD_POINT: begin
                            if (out_space) r_state <= S_IDLE;
                        end
                        CMD_CIRCLE: begin
                            if (out_space) begin
                                r_state <= (r_vert == LAST_VERT) ? S_IDLE : S_COR;
                            end
                        end
                        default: begin
                            if (r_job.aligned) begin
                                if (r_corner != 2'd3) begin
                                    r_state <= S_M0;
                                end else begin
                                    r_state <= (r_job.item.command == CMD_RRECT) ? S_R0
                                                                                 : S_RECT;
                                end
                            end else if (out_space) begin
                                r_state <= (r_corner == 2'd3) ? S_IDLE : S_M0;
                            end
                        end
                    endcase
                end
                S_R0:   r_state <= S_R1;
                S_R1:   r_state <= S_RECT;
                S_RECT: begin
                    if (out_space) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    r_job    <= i_job;
                    r_corner <= 2'd0;
                    r_px     <= i_job.item.ax;
                    r_py     <= i_job.item.ay;
                    r_vert   <= '0;
                    r_turn   <= '0;
                    r_rem    <= '0;
                    r_cx     <= CORDIC_GAIN;
                    r_cy     <= '0;
                    r_cz     <= '0;
                    r_cq     <= 2'd0;
                    r_k      <= 5'd0;
                end
            end
            S_COR: begin
                if (!r_cz[31]) begin
                    r_cx <= r_cx - ysh;
                    r_cy <= r_cy + xsh;
                    r_cz <= r_cz - atan_turn(r_k);
                end else begin
                    r_cx <= r_cx + ysh;
                    r_cy <= r_cy - xsh;
                    r_cz <= r_cz + atan_turn(r_k);
                end
                r_k <= r_k + 5'd1;
            end
            S_CQ: begin
                unique case (r_cq)
                    2'd0:    begin r_c <= r_cx;  r_s <= r_cy;  end
                    2'd1:    begin r_c <= -r_cy; r_s <= r_cx;  end
                    2'd2:    begin r_c <= -r_cx; r_s <= -r_cy; end
                    default: begin r_c <= r_cy;  r_s <= -r_cx; end
                endcase
            end
            S_CMS: r_px <= sat32((r_prod >>> 30) + PW'(r_job.item.ax));
            S_CPY: r_py <= sat32((r_prod >>> 30) + PW'(r_job.item.ay));
            S_M1:  r_acc <= r_prod;
            S_M2:  r_acc <= r_acc + r_prod;
            S_M3: begin
                r_tx  <= sat32(shifted + PW'(i_cfg.offset_x));
                r_acc <= r_prod;
            end
            S_M4:  r_acc <= r_acc + r_prod;
            S_M5:  r_ty <= sat32(shifted + PW'(i_cfg.offset_y));
            S_EMIT: begin
                if (r_job.item.command == CMD_CIRCLE) begin
                    if (out_space) begin
                        r_vert <= r_vert + VERT_W'(1);
                        r_turn <= nxt_turn;
                        r_rem  <= nxt_rem;
                        r_cx   <= CORDIC_GAIN;
                        r_cy   <= '0;
                        r_cz   <= 32'({2'b00, nxt_turn[29:0]});
                        r_cq   <= nxt_turn[31:30];
                        r_k    <= 5'd0;
                    end
                end else if (r_job.item.command != CMD_POINT) begin
                    if (r_job.aligned) begin
                        r_l   <= nl;
                        r_r   <= nr;
                        r_t   <= nt;
                        r_b   <= nb;
                        r_rnd <= '0;
                    end
                    if (r_job.aligned || out_space) begin
                        r_corner <= nxt_corner;
                        r_px <= (nxt_corner == 2'd1 || nxt_corner == 2'd2) ? r_job.item.bx
                                                                           : r_job.item.ax;
                        r_py <= nxt_corner[1] ? r_job.item.by_coord : r_job.item.ay;
                    end
                end
            end
            S_R1: begin
                r_rnd <= (rnd_full > PW'(64'sd2147483647)) ? 31'h7FFFFFFF : rnd_full[30:0];
            end
            default: ;
        endcase
    end

    // Result queue.
    assign empty    = (r_ocnt == 2'd0);
    assign o_result = r_omem[r_ord];
    assign do_opop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) r_owr <= !r_owr;
            if (do_opop) r_ord <= !r_ord;
            r_ocnt <= r_ocnt + 2'(opush) - 2'(do_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_omem[r_owr] <= oitem;
        end
    end

endmodule

FILE: sv/clip_shape_affine_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_shape_affine_transform_unit
// Applies a 2x2 matrix plus offset to clip shapes in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// Shapes enter as queue pushes (push/full) and results leave as queue pops
// (empty/pop); a push transaction is taken when push is high and full low.
// The matrix, offsets and alignment tolerance must be written through the
// plain configuration port only while idle; the unit does not enforce it.
// A two-entry job queue parts the front end from the sequencer, and a
// two-entry result queue parts the sequencer from the receiver, so shapes
// keep arriving while results wait.
// Each point transform runs through states S_M0 to S_M5 on the one shared
// multiplier, then S_EMIT. A rectangle runs this for each of its four corners
// (an aligned bounding rectangle then adds S_RECT, and a rounded rectangle's
// rounding scale adds S_R0 and S_R1 before it); a circle vertex first runs
// the 30-step iterative CORDIC rotator and S_CQ to S_CPY, and a whole circle
// repeats this for each of its N_VERT vertices.
// One shape is processed at a time.
// Reset clears both queues and loads the identity matrix.
// When the receiver stalls, the result queue fills and the sequencer holds.
// ----------------------------------------------------------------------------
module clip_shape_affine_transform_unit
    import csat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result
);

    t_cfg cfg;
    logic job_valid;
    t_job job;
    logic job_pop;

    // Front end: configuration, classification and job queue.
    csat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cfg       (cfg),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // Back end: shape sequencer and result queue.
    csat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clip shape affine transform unit.
// ----------------------------------------------------------------------------
// Shapes are queued by a stimulus process and pushed by a driver at random
// gaps. A monitor predicts every accepted shape with a bit-true model of the
// matrix transform, saturation, rounding scale and CORDIC circle vertices,
// and compares each popped result, field by field, with the oldest prediction.
// The matrix is rewritten between phases while the unit is idle, covering
// aligned, sheared and extreme settings.
// ----------------------------------------------------------------------------
module tb;
    import csat_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  LONG_HOLD      = 400;
    localparam longint FRAC_MASK   = (64'sd1 <<< FRAC_BITS) - 1;
    localparam longint INT_MAX32   = 64'sd2147483647;
    localparam longint INT_MIN32   = -64'sd2147483648;

    // Arctangent steps in turn units (2^32 per full turn).
    localparam longint ATAN_STEP [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1};
    localparam longint CORDIC_K = 652032874;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_result;

    t_in_item  shapes_to_send [$];
    t_out_item expected_vertices [$];
    t_cfg      matrix_shadow;
    int        mismatch_count = 0;
    int        send_gap_pct = 0;
    int        take_gap_pct = 0;
    bit        hold_request = 1'b0;
    int        idle_cycles = 0;
    bit        in_taken = 1'b0;

    clip_shape_affine_transform_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Queue helpers.
    function automatic void expect_result(input t_out_item o);
        expected_vertices = {expected_vertices, o};
    endfunction

    function automatic void queue_shape(input t_in_item s);
        shapes_to_send = {shapes_to_send, s};
    endfunction

    // ------------------------------------------------------------------------
    // Transform model
    // ------------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > INT_MAX32) return INT_MAX32;
        if (v < INT_MIN32) return INT_MIN32;
        return v;
    endfunction

    // Exact floor of (a*ma + b*mb) / 2^FRAC_BITS.
    function automatic longint scaled_dot(input longint a, input longint ma,
                                          input longint b, input longint mb);
        longint p1, p2, lo;
        p1 = a * ma;
        p2 = b * mb;
        lo = (p1 & FRAC_MASK) + (p2 & FRAC_MASK);
        return (p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS) + (lo >>> FRAC_BITS);
    endfunction

    function automatic void map_point(input longint x, input longint y,
                                      output longint ox, output longint oy);
        ox = clamp32(scaled_dot(x, longint'(matrix_shadow.mat_xx),
                                y, longint'(matrix_shadow.mat_yx))
                     + longint'(matrix_shadow.offset_x));
        oy = clamp32(scaled_dot(x, longint'(matrix_shadow.mat_xy),
                                y, longint'(matrix_shadow.mat_yy))
                     + longint'(matrix_shadow.offset_y));
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Cosine and sine in Q30 of a turn fraction.
    function automatic void turn_cos_sin(input logic [31:0] turn,
                                         output longint c, output longint s);
        longint x, y, z, nx;
        x = CORDIC_K;
        y = 0;
        z = longint'({2'b00, turn[29:0]});
        for (int k = 0; k < 30; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ATAN_STEP[k];
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ATAN_STEP[k];
            end
            x = nx;
        end
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_out_item make_vertex(input longint x, input longint y,
                                              input logic last);
        t_out_item r;
        r = '0;
        r.kind     = KIND_VERTEX;
        r.out_ax   = x[31:0];
        r.out_ay   = y[31:0];
        r.last_out = last;
        return r;
    endfunction

    // Expected results of one accepted shape, appended in output order.
    function automatic void predict_shape(input t_in_item s);
        longint px [4], py [4];
        longint c, sn, x, y, l, t, r, b, eps, scale, rnd;
        longint unsigned turn64;
        t_out_item o;
        if (s.command == CMD_POINT) begin
            map_point(longint'(s.ax), longint'(s.ay), px[0], py[0]);
            expect_result(make_vertex(px[0], py[0], s.last_point));
        end else if (s.command == CMD_CIRCLE) begin
            for (int i = 0; i < N_VERT; i++) begin
                turn64 = (longint'(i) << 32) / SEGMENTS;
                turn_cos_sin(turn64[31:0], c, sn);
                x = clamp32(longint'(s.ax) + ((c * longint'(s.size_value)) >>> 30));
                y = clamp32(longint'(s.ay) + ((sn * longint'(s.size_value)) >>> 30));
                map_point(x, y, px[0], py[0]);
                expect_result(make_vertex(px[0], py[0], i == N_VERT - 1));
            end
        end else begin
            map_point(longint'(s.ax), longint'(s.ay), px[0], py[0]);
            map_point(longint'(s.bx), longint'(s.ay), px[1], py[1]);
            map_point(longint'(s.bx), longint'(s.by_coord), px[2], py[2]);
            map_point(longint'(s.ax), longint'(s.by_coord), px[3], py[3]);
            eps = longint'({48'd0, matrix_shadow.align_epsilon});
            if (mag(longint'(matrix_shadow.mat_xy)) > eps ||
                mag(longint'(matrix_shadow.mat_yx)) > eps) begin
                for (int i = 0; i < 4; i++) begin
                    expect_result(make_vertex(px[i], py[i], i == 3));
                end
            end else begin
                l = px[0]; r = px[0]; t = py[0]; b = py[0];
                for (int i = 1; i < 4; i++) begin
                    if (px[i] < l) l = px[i];
                    if (px[i] > r) r = px[i];
                    if (py[i] < t) t = py[i];
                    if (py[i] > b) b = py[i];
                end
                rnd = 0;
                if (s.command == CMD_RRECT) begin
                    scale = mag(longint'(matrix_shadow.mat_xx));
                    if (mag(longint'(matrix_shadow.mat_yy)) > scale) begin
                        scale = mag(longint'(matrix_shadow.mat_yy));
                    end
                    rnd = (longint'(s.size_value) * scale) >>> FRAC_BITS;
                    if (rnd > INT_MAX32) rnd = INT_MAX32;
                end
                o = '0;
                o.kind         = (s.command == CMD_RRECT) ? KIND_RRECT : KIND_RECT;
                o.out_ax       = l[31:0];
                o.out_ay       = t[31:0];
                o.out_bx       = r[31:0];
                o.out_by       = b[31:0];
                o.out_rounding = rnd[30:0];
                o.last_out     = 1'b1;
                expect_result(o);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predicts accepted shapes and checks popped results.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_shape(i_item);
            end
            if (pop && !empty) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected result", o_result.out_ax, 32'd0);
                end else begin
                    want = expected_vertices.pop_front();
                    if (o_result.kind != want.kind)
                        report_mismatch("kind", o_result.kind, want.kind);
                    if (o_result.out_ax != want.out_ax)
                        report_mismatch("out_ax", o_result.out_ax, want.out_ax);
                    if (o_result.out_ay != want.out_ay)
                        report_mismatch("out_ay", o_result.out_ay, want.out_ay);
                    if (o_result.out_bx != want.out_bx)
                        report_mismatch("out_bx", o_result.out_bx, want.out_bx);
                    if (o_result.out_by != want.out_by)
                        report_mismatch("out_by", o_result.out_by, want.out_by);
                    if (o_result.out_rounding != want.out_rounding)
                        report_mismatch("out_rounding", o_result.out_rounding,
                                        want.out_rounding);
                    if (o_result.last_out != want.last_out)
                        report_mismatch("last_out", o_result.last_out, want.last_out);
                end
            end
        end
    end

    // Watchdog: counts cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_wr_en || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Remember whether the offered shape was taken at the last rising edge.
    always @(posedge i_clk) begin
        in_taken <= push && !full;
    end

    // ------------------------------------------------------------------------
    // Driver: offers queued shapes, holds each until it is taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || in_taken)) begin
            if (shapes_to_send.size() != 0 &&
                $urandom_range(99) >= send_gap_pct) begin
                push   <= 1'b1;
                i_item <= shapes_to_send.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random pop gaps, plus one long hold-off on request.
    always @(negedge i_clk) begin
        int  hold_left;
        bit  hold_done;
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n && ($urandom_range(99) >= take_gap_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_MAT_XX:   matrix_shadow.mat_xx = data;
            REG_MAT_XY:   matrix_shadow.mat_xy = data;
            REG_MAT_YX:   matrix_shadow.mat_yx = data;
            REG_MAT_YY:   matrix_shadow.mat_yy = data;
            REG_OFFSET_X: matrix_shadow.offset_x = data;
            REG_OFFSET_Y: matrix_shadow.offset_y = data;
            default:      matrix_shadow.align_epsilon = data[15:0];
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_matrix(input logic [31:0] xx, input logic [31:0] xy,
                               input logic [31:0] yx, input logic [31:0] yy,
                               input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] eps);
        write_reg(REG_MAT_XX, xx);
        write_reg(REG_MAT_XY, xy);
        write_reg(REG_MAT_YX, yx);
        write_reg(REG_MAT_YY, yy);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_ALIGN_EPS, eps);
    endtask

    // Wait until every shape is taken and every result has come back.
    task automatic drain();
        do @(posedge i_clk);
        while (shapes_to_send.size() != 0 || push || expected_vertices.size() != 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            2: case ($urandom_range(3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'hFFFF_FFFF;
                   default: return 32'h0;
               endcase
            default: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
        endcase
    endfunction

    // Matrix entry around a few units, sometimes full range.
    function automatic logic [31:0] pick_factor();
        if ($urandom_range(4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endfunction

    function automatic t_in_item random_shape();
        t_in_item s;
        int roll;
        roll = $urandom_range(99);
        s.command    = (roll < 28) ? CMD_RECT : (roll < 50) ? CMD_RRECT :
                       (roll < 96) ? CMD_POINT : CMD_CIRCLE;
        s.ax         = pick_coord();
        s.ay         = pick_coord();
        s.bx         = pick_coord();
        s.by_coord   = pick_coord();
        s.size_value = ($urandom_range(2) == 0) ? 31'($urandom) :
                       31'($urandom_range(0, 1 << 22));
        s.last_point = $urandom_range(1);
        return s;
    endfunction

    function automatic t_in_item shape(input logic [1:0] cmd, input logic [31:0] ax,
                                       input logic [31:0] ay, input logic [31:0] bx,
                                       input logic [31:0] by, input logic [30:0] sz,
                                       input logic lp);
        t_in_item s;
        s.command = cmd; s.ax = ax; s.ay = ay; s.bx = bx; s.by_coord = by;
        s.size_value = sz; s.last_point = lp;
        return s;
    endfunction

    initial begin
        logic [31:0] xy, yx, eps;
        matrix_shadow = '{mat_xx: ONE_FIX, mat_xy: 0, mat_yx: 0, mat_yy: ONE_FIX,
                          offset_x: 0, offset_y: 0, align_epsilon: 16'd1};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed shapes under the reset matrix.
        queue_shape(shape(CMD_RECT, 32'h0001_0000, 32'h0002_0000,
                          32'h0005_0000, 32'h0007_0000, 0, 0));
        queue_shape(shape(CMD_RECT, 32'h0005_0000, 32'h0007_0000,
                          32'hFFFF_0000, 32'h0000_8000, 0, 1));
        queue_shape(shape(CMD_RRECT, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        queue_shape(shape(CMD_RRECT, 0, 0, 32'h0010_0000, 32'h0010_0000,
                          31'h0002_0000, 0));
        queue_shape(shape(CMD_POINT, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0));
        queue_shape(shape(CMD_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1));
        queue_shape(shape(CMD_CIRCLE, 0, 0, 0, 0, 0, 0));
        queue_shape(shape(CMD_CIRCLE, 32'h0010_0000, 32'hFFF0_0000, 0, 0,
                          31'h0004_0000, 1));
        queue_shape(shape(CMD_CIRCLE, 32'h7FFF_0000, 32'h8000_0000, 0, 0,
                          31'h7FFF_FFFF, 0));
        drain();

        // Sheared matrix with saturating offsets: rectangles become polygons.
        load_matrix(32'h0000_B505, 32'h0000_B505, 32'hFFFF_4AFB, 32'h0000_B505,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        queue_shape(shape(CMD_RECT, 32'hFFF0_0000, 32'hFFF0_0000,
                          32'h0010_0000, 32'h0010_0000, 0, 0));
        queue_shape(shape(CMD_RRECT, 0, 0, 32'h0003_0000, 32'h0001_0000,
                          31'h0001_0000, 1));
        queue_shape(shape(CMD_CIRCLE, 0, 0, 0, 0, 31'h0008_0000, 0));
        drain();

        // Extreme factors, shear right at the widest tolerance.
        load_matrix(32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0001, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
        queue_shape(shape(CMD_RRECT, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h0000_0001, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0));
        queue_shape(shape(CMD_RRECT, 32'h0000_0001, 32'h0000_0001,
                          32'h0000_0002, 32'h0000_0002, 31'h0000_0003, 0));
        queue_shape(shape(CMD_RECT, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
        queue_shape(shape(CMD_POINT, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 1));
        drain();

        // Tolerance of zero with extreme shear entries.
        load_matrix(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                    32'h0, 32'h0, 32'h0);
        queue_shape(shape(CMD_RECT, 32'h0000_1000, 32'h0000_2000,
                          32'h0000_3000, 32'h0000_4000, 0, 0));
        queue_shape(shape(CMD_CIRCLE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                          31'h0100_0000, 1));
        drain();

        // Random phases: sender gaps then receiver gaps, swapped, then none.
        for (int phase = 0; phase < 6; phase++) begin
            send_gap_pct = (phase < 2) ? 38 : (phase < 4) ? 57 : 0;
            take_gap_pct = (phase < 2) ? 57 : (phase < 4) ? 38 : 0;
            eps = (phase == 5) ? 32'h0000_FFFF : $urandom_range(0, 4096);
            if (phase % 2 == 0) begin
                xy = $urandom_range(0, eps[15:0]);
                yx = -$urandom_range(0, eps[15:0]);
            end else begin
                xy = pick_factor();
                yx = pick_factor();
            end
            load_matrix(pick_factor(), xy, yx, pick_factor(), pick_coord(),
                        pick_coord(), eps);
            if (phase == 4) hold_request = 1'b1;
            for (int n = 0; n < 80; n++) begin
                queue_shape(random_shape());
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/csat_pkg.sv
sv/csat_front.sv
sv/csat_back.sv
sv/clip_shape_affine_transform_unit.sv
dv/tb.sv
